>>> rtl/chull_pkg.sv
package chull_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SORT,
    ST_INIT,
    ST_POP,
    ST_SCAN,
    ST_SPLIT,
    ST_ORDER,
    ST_EMIT
  } chull_state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;
    logic sort_start;
    logic init;
    logic pop;
    logic scan_start;
    logic split;
    logic order_start;
    logic emit_start;
    logic clear_set;
  } chull_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic sort_done;
    logic empty;
    logic stack_empty;
    logic scan_done;
    logic order_done;
    logic emit_done;
  } chull_sts_t;

endpackage

>>> rtl/chull_ctrl.sv
module chull_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 in_last_point,
  input  chull_pkg::chull_sts_t sts,
  output chull_pkg::chull_cmd_t cmd,
  output logic                 busy
);
  import chull_pkg::*;

  chull_state_t state_r, state_nxt;

  // hold state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (start && in_last_point) state_nxt = ST_SORT;
      ST_SORT:  if (sts.sort_done) state_nxt = sts.empty ? ST_IDLE : ST_INIT;
      ST_INIT:  state_nxt = ST_POP;
      ST_POP:   state_nxt = sts.stack_empty ? ST_ORDER : ST_SCAN;
      ST_SCAN:  if (sts.scan_done) state_nxt = ST_SPLIT;
      ST_SPLIT: state_nxt = ST_POP;
      ST_ORDER: if (sts.order_done) state_nxt = ST_EMIT;
      ST_EMIT:  if (sts.emit_done) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd = '0;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        cmd.load = start;
        cmd.sort_start = start && in_last_point;
      end
      ST_SORT: cmd.init = sts.sort_done && !sts.empty;
      ST_INIT: ;
      ST_POP: begin
        cmd.pop = !sts.stack_empty;
        cmd.order_start = sts.stack_empty;
      end
      ST_SCAN:  ;
      ST_SPLIT: cmd.split = 1'b1;
      ST_ORDER: cmd.emit_start = sts.order_done;
      ST_EMIT:  cmd.clear_set = sts.emit_done;
      default:  ;
    endcase
    if (state_r == ST_SORT && sts.sort_done && sts.empty) cmd.clear_set = 1'b1;
    if (state_r == ST_POP && !sts.stack_empty) cmd.scan_start = 1'b1;
  end

endmodule

>>> rtl/chull_dp.sv
module chull_dp #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  chull_pkg::chull_cmd_t         cmd,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  output chull_pkg::chull_sts_t         sts,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_vertex_x,
  output logic signed [COORD_BITS-1:0] out_vertex_y,
  output logic                         out_last_vertex,
  output logic                         out_points_dropped
);
  import chull_pkg::*;

  localparam int IW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW + 1;

  // point registers: compact sorted list kept in flip-flops (small store)
  logic signed [COORD_BITS-1:0] px_r [MAX_POINTS];
  logic signed [COORD_BITS-1:0] py_r [MAX_POINTS];
  logic signed [COORD_BITS-1:0] ux_r [MAX_POINTS];
  logic signed [COORD_BITS-1:0] uy_r [MAX_POINTS];
  logic [MAX_POINTS-1:0]        onh_r;
  logic [CW-1:0]                pcnt_r, n_r;
  logic                         ovf_r;

  // segment stack
  logic [IW-1:0] sa_r [MAX_POINTS];
  logic [IW-1:0] sb_r [MAX_POINTS];
  logic          ss_r [MAX_POINTS];
  logic [CW-1:0] sp_r;

  // sort walker
  logic          sorting_r;
  logic [CW-1:0] si_r;
  logic [CW-1:0] sj_r;
  logic          sdup_r;
  logic [1:0]    sph_r;

  // scan walker
  logic          scanning_r;
  logic [CW-1:0] ci_r;
  logic [IW-1:0] ca_r, cb_r;
  logic          cs_r;
  logic          found_r;
  logic [IW-1:0] best_r;
  logic [PW-1:0] maxd_r;
  logic          sdone_r;
  logic signed [PW-1:0] prod1_r, prod2_r;
  logic          pvalid_r;
  logic [IW-1:0] pidx_r;

  // hull ordering walker
  logic signed [COORD_BITS-1:0] hx_r [MAX_POINTS];
  logic signed [COORD_BITS-1:0] hy_r [MAX_POINTS];
  logic [CW-1:0] hc_r;
  logic          ordering_r;
  logic [CW-1:0] oi_r, oj_r;
  logic [1:0]    oph_r;
  logic signed [PW-1:0] op1_r, op2_r;
  logic          odone_r;

  // emit walker
  logic          emitting_r;
  logic [CW-1:0] ek_r;
  logic          edone_r;

  logic signed [DW-1:0] ax, ay, bx, by, qx, qy;
  logic signed [PW-1:0] c;
  logic [PW-1:0]        dabs;
  logic                 want;
  logic signed [COORD_BITS-1:0] cpx, cpy;
  logic                 bef;
  logic signed [DW-1:0] rx, ry, hqx, hqy, ppx, ppy;
  logic [IW-1:0]        emi;

  assign sts.sort_done  = sorting_r && (si_r == pcnt_r);
  assign sts.empty      = (n_r == '0);
  assign sts.stack_empty = (sp_r == '0);
  assign sts.scan_done  = sdone_r;
  assign sts.order_done = odone_r;
  assign sts.emit_done  = edone_r;

  // sort-phase comparands
  assign cpx = px_r[si_r[IW-1:0]];
  assign cpy = py_r[si_r[IW-1:0]];
  assign bef = (sj_r != '0) &&
               ((cpx < ux_r[sj_r[IW-1:0]-1'b1]) ||
                (cpx == ux_r[sj_r[IW-1:0]-1'b1] && cpy < uy_r[sj_r[IW-1:0]-1'b1]));

  // scan arithmetic: area of u[ci] relative to line a-b
  assign ax = DW'(ux_r[ca_r]);
  assign ay = DW'(uy_r[ca_r]);
  assign bx = DW'(ux_r[cb_r]);
  assign by = DW'(uy_r[cb_r]);
  assign qx = DW'(ux_r[ci_r[IW-1:0]]);
  assign qy = DW'(uy_r[ci_r[IW-1:0]]);
  assign c = prod1_r - prod2_r;
  assign dabs = c[PW-1] ? PW'(-c) : PW'(c);
  assign want = (c != '0) && (c[PW-1] == cs_r) && (dabs > maxd_r);

  // ordering arithmetic
  assign rx  = DW'(hx_r[0]);
  assign ry  = DW'(hy_r[0]);
  assign hqx = DW'(hx_r[oj_r[IW-1:0]-1'b1]);
  assign hqy = DW'(hy_r[oj_r[IW-1:0]-1'b1]);
  assign ppx = DW'(ux_r[oi_r[IW-1:0]]);
  assign ppy = DW'(uy_r[oi_r[IW-1:0]]);

  assign emi = (ek_r == '0 || ek_r == hc_r) ? '0 : IW'(hc_r - ek_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pcnt_r <= '0;
      ovf_r <= 1'b0;
      n_r <= '0;
      sp_r <= '0;
      hc_r <= '0;
      sorting_r <= 1'b0;
      scanning_r <= 1'b0;
      ordering_r <= 1'b0;
      emitting_r <= 1'b0;
      sdone_r <= 1'b0;
      odone_r <= 1'b0;
      edone_r <= 1'b0;
      pvalid_r <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      sdone_r <= 1'b0;
      odone_r <= 1'b0;
      edone_r <= 1'b0;
      out_valid <= 1'b0;

      // load one point
      if (cmd.load) begin
        if (pcnt_r < CW'(MAX_POINTS)) begin
          px_r[pcnt_r[IW-1:0]] <= in_point_x;
          py_r[pcnt_r[IW-1:0]] <= in_point_y;
          pcnt_r <= pcnt_r + 1'b1;
        end else begin
          ovf_r <= 1'b1;
        end
      end
      if (cmd.sort_start) begin
        sorting_r <= 1'b1;
        si_r <= '0;
        sj_r <= '0;
        sph_r <= 2'd0;
        sdup_r <= 1'b0;
        n_r <= '0;
      end

      // insertion sort with duplicate merge, one compare per cycle
      if (sorting_r && si_r != pcnt_r) begin
        case (sph_r)
          2'd0: begin
            if (sj_r == n_r) begin
              if (sdup_r) begin
                si_r <= si_r + 1'b1;
                sj_r <= '0;
                sdup_r <= 1'b0;
              end else begin
                sph_r <= 2'd1;
                sj_r <= n_r;
              end
            end else begin
              if (ux_r[sj_r[IW-1:0]] == cpx && uy_r[sj_r[IW-1:0]] == cpy) sdup_r <= 1'b1;
              sj_r <= sj_r + 1'b1;
            end
          end
          default: begin
            if (bef) begin
              ux_r[sj_r[IW-1:0]] <= ux_r[sj_r[IW-1:0]-1'b1];
              uy_r[sj_r[IW-1:0]] <= uy_r[sj_r[IW-1:0]-1'b1];
              sj_r <= sj_r - 1'b1;
            end else begin
              ux_r[sj_r[IW-1:0]] <= cpx;
              uy_r[sj_r[IW-1:0]] <= cpy;
              n_r <= n_r + 1'b1;
              si_r <= si_r + 1'b1;
              sj_r <= '0;
              sph_r <= 2'd0;
            end
          end
        endcase
      end
      if (sts.sort_done && (cmd.init || cmd.clear_set)) sorting_r <= 1'b0;

      // seed the stack with both sides of the extreme chord
      if (cmd.init) begin
        onh_r <= '0;
        onh_r[0] <= 1'b1;
        onh_r[n_r[IW-1:0]-1'b1] <= 1'b1;
        sa_r[0] <= '0;
        sb_r[0] <= IW'(n_r - 1'b1);
        ss_r[0] <= 1'b0;
        sa_r[1] <= '0;
        sb_r[1] <= IW'(n_r - 1'b1);
        ss_r[1] <= 1'b1;
        sp_r <= CW'(2);
      end

      // pop a segment and start a scan
      if (cmd.pop) begin
        ca_r <= sa_r[sp_r[IW-1:0]-1'b1];
        cb_r <= sb_r[sp_r[IW-1:0]-1'b1];
        cs_r <= ss_r[sp_r[IW-1:0]-1'b1];
        sp_r <= sp_r - 1'b1;
      end
      if (cmd.scan_start) begin
        scanning_r <= 1'b1;
        ci_r <= '0;
        found_r <= 1'b0;
        maxd_r <= '0;
        pvalid_r <= 1'b0;
      end

      // scan: multiply stage, then compare stage
      if (scanning_r) begin
        if (ci_r != n_r) begin
          prod1_r <= PW'((ay - by) * (qx - bx));
          prod2_r <= PW'((qy - by) * (ax - bx));
          pidx_r <= ci_r[IW-1:0];
          pvalid_r <= 1'b1;
          ci_r <= ci_r + 1'b1;
        end else begin
          pvalid_r <= 1'b0;
          if (!pvalid_r) begin
            scanning_r <= 1'b0;
            sdone_r <= 1'b1;
          end
        end
        if (pvalid_r && want) begin
          found_r <= 1'b1;
          best_r <= pidx_r;
          maxd_r <= dabs;
        end
      end

      // split: mark best and push the two child segments, or close the edge
      if (cmd.split) begin
        if (!found_r) begin
          onh_r[ca_r] <= 1'b1;
          onh_r[cb_r] <= 1'b1;
        end else begin
          onh_r[best_r] <= 1'b1;
          // child a: best->a, outside lies away from b, so the side flips
          sa_r[sp_r[IW-1:0]] <= best_r;
          sb_r[sp_r[IW-1:0]] <= ca_r;
          ss_r[sp_r[IW-1:0]] <= ~cs_r;
          // child b: best->b, outside lies away from a, same side as parent
          sa_r[sp_r[IW-1:0]+1'b1] <= best_r;
          sb_r[sp_r[IW-1:0]+1'b1] <= cb_r;
          ss_r[sp_r[IW-1:0]+1'b1] <= cs_r;
          sp_r <= sp_r + CW'(2);
        end
      end

      // order hull vertices counterclockwise about u[0]
      if (cmd.order_start) begin
        ordering_r <= 1'b1;
        oi_r <= '0;
        hc_r <= '0;
        oph_r <= 2'd0;
      end
      if (ordering_r) begin
        case (oph_r)
          2'd0: begin
            if (oi_r == n_r) begin
              ordering_r <= 1'b0;
              odone_r <= 1'b1;
            end else if (!onh_r[oi_r[IW-1:0]]) begin
              oi_r <= oi_r + 1'b1;
            end else begin
              oj_r <= hc_r;
              oph_r <= 2'd1;
            end
          end
          2'd1: begin
            if (oj_r > CW'(1)) begin
              op1_r <= PW'((hqx - rx) * (ppy - ry));
              op2_r <= PW'((hqy - ry) * (ppx - rx));
              oph_r <= 2'd2;
            end else begin
              hx_r[oj_r[IW-1:0]] <= ux_r[oi_r[IW-1:0]];
              hy_r[oj_r[IW-1:0]] <= uy_r[oi_r[IW-1:0]];
              hc_r <= hc_r + 1'b1;
              oi_r <= oi_r + 1'b1;
              oph_r <= 2'd0;
            end
          end
          default: begin
            if (op1_r - op2_r >= 0) begin
              hx_r[oj_r[IW-1:0]] <= ux_r[oi_r[IW-1:0]];
              hy_r[oj_r[IW-1:0]] <= uy_r[oi_r[IW-1:0]];
              hc_r <= hc_r + 1'b1;
              oi_r <= oi_r + 1'b1;
              oph_r <= 2'd0;
            end else begin
              hx_r[oj_r[IW-1:0]] <= hx_r[oj_r[IW-1:0]-1'b1];
              hy_r[oj_r[IW-1:0]] <= hy_r[oj_r[IW-1:0]-1'b1];
              oj_r <= oj_r - 1'b1;
              oph_r <= 2'd1;
            end
          end
        endcase
      end

      // emit: first vertex, the rest in reverse, then the first again
      if (cmd.emit_start) begin
        emitting_r <= 1'b1;
        ek_r <= '0;
      end
      if (emitting_r) begin
        out_valid <= 1'b1;
        out_vertex_x <= hx_r[emi];
        out_vertex_y <= hy_r[emi];
        out_last_vertex <= (ek_r == hc_r);
        out_points_dropped <= ovf_r;
        ek_r <= ek_r + 1'b1;
        if (ek_r == hc_r) begin
          emitting_r <= 1'b0;
          edone_r <= 1'b1;
        end
      end

      if (cmd.clear_set) begin
        pcnt_r <= '0;
        ovf_r <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/convex_hull_2d_top.sv
// Channel  | Ports                                              | Transfer
// input    | in_point_x, in_point_y, in_last_point              | start && !busy
// result   | out_vertex_x, out_vertex_y, out_last_vertex,
//          | out_points_dropped                                 | out_valid
//
// A point without the last mark is stored. A last point starts the hull: sort
// with duplicate merge, then each quickhull segment a scan through one shared
// multiplier pair, then ordering, then H+1 results, one per cycle. Reset is
// synchronous and clears all control state. The receiver cannot stall; results
// go out once, back to back.
module convex_hull_2d_top #(
  parameter int MAX_POINTS = 32,
  parameter int COORD_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_last_point,
  output logic                         out_valid,
  output logic signed [COORD_BITS-1:0] out_vertex_x,
  output logic signed [COORD_BITS-1:0] out_vertex_y,
  output logic                         out_last_vertex,
  output logic                         out_points_dropped
);
  import chull_pkg::*;

  chull_cmd_t cmd;
  chull_sts_t sts;

  chull_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .in_last_point(in_last_point),
    .sts(sts), .cmd(cmd), .busy(busy)
  );

  chull_dp #(.MAX_POINTS(MAX_POINTS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk(clk), .rst_n(rst_n), .cmd(cmd), .in_point_x(in_point_x),
    .in_point_y(in_point_y), .sts(sts), .out_valid(out_valid),
    .out_vertex_x(out_vertex_x), .out_vertex_y(out_vertex_y),
    .out_last_vertex(out_last_vertex), .out_points_dropped(out_points_dropped)
  );

`ifndef NO_ASSERTIONS
  a_no_out_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(busy)) else $error("result while idle");
  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_vertex) |=> !out_valid) else $error("result after closing vertex");
`endif

endmodule
